[hw/rtl/ptac_pkg.sv]
// Package for the partition table access checker: field structs, command and
// status codes, packing constants and the register map. No dependencies.
package ptac_pkg;

  // Default table depth
  localparam int MAX_PARTITIONS_DEF = 7;

  // Superblock packing
  localparam int FLAG_BITS  = 4;
  localparam int START_BITS = 12;
  localparam logic [START_BITS-1:0] START_STOP = 12'hFFF;
  localparam logic [START_BITS-1:0] MIN_START  = 12'd2;
  localparam int PACKED_W = 88;

  // Device geometry
  localparam int BLOCK_SHIFT = 4;
  localparam int BLOCK_BYTES = 16;
  localparam int BCNT_W = 13;
  localparam logic [BCNT_W-1:0] BCNT_MIN   = 13'd2;
  localparam logic [BCNT_W-1:0] BCNT_MAX   = 13'd4096;
  localparam logic [BCNT_W-1:0] BCNT_RESET = 13'd4096;

  // Commands
  localparam logic [2:0] CMD_LOAD     = 3'd0;
  localparam logic [2:0] CMD_SET_NAME = 3'd1;
  localparam logic [2:0] CMD_FIND     = 3'd2;
  localparam logic [2:0] CMD_BYTE     = 3'd3;
  localparam logic [2:0] CMD_BLOCK    = 3'd4;
  localparam logic [2:0] CMD_IN_BLOCK = 3'd5;
  localparam logic [2:0] CMD_SIZE     = 3'd6;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_READY = 3'd1;
  localparam logic [2:0] ST_RANGE     = 3'd2;
  localparam logic [2:0] ST_READ_ONLY = 3'd3;
  localparam logic [2:0] ST_UNALIGNED = 3'd4;
  localparam logic [2:0] ST_GEOMETRY  = 3'd5;

  // Register map (index = byte address / 4)
  localparam int PADDR_W = 3;
  localparam logic REG_BLOCK_COUNT = 1'b0;
  localparam logic REG_WRITABLE    = 1'b1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        end_marker;
    logic [63:0] packed_low;
    logic [23:0] packed_high;
    logic [2:0]  part_index;
    logic [15:0] offset;
    logic [7:0]  byte_in_block;
    logic [15:0] length;
    logic        is_write;
    logic [15:0] name_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        issue_access;
    logic [15:0] address;
    logic        found;
    logic [2:0]  found_index;
    logic [12:0] size_blocks;
    logic [2:0]  part_count;
  } out_item_t;

endpackage

[hw/rtl/partition_table_access_check.sv]
// Partition table access checker: top level with the table, the command logic
// and the APB register port. Depends on ptac_pkg.
//
// Each command beat is checked in one pass of logic and its result lands in an
// output register, so the block takes one beat per clock while its results
// are taken, and the result shows in the cycle after acceptance. The output
// register is the only stage: a new beat is taken whenever the register is
// empty or its result is taken in the same cycle. A load updates the table in
// the cycle it is accepted, so the very next beat sees the new table.
// Registers: block_count at byte address 0 (13 bits, reset 4096), writable at
// address 4 (1 bit, reset 1); write them only while no beat is in flight.
module partition_table_access_check
  import ptac_pkg::*;
#(
  parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // Configuration registers
  logic [BCNT_W-1:0] block_count;
  logic              writable;

  // Partition table and name store
  logic [START_BITS-1:0] begin_block [0:MAX_PARTITIONS-1];
  logic [BCNT_W-1:0]     end_block   [0:MAX_PARTITIONS-1];
  logic [15:0]           name_store  [0:MAX_PARTITIONS-1];
  logic [2:0]            partition_total;
  logic                  mounted;
  logic                  names_valid;

  // Next values
  logic [START_BITS-1:0] begin_block_next [0:MAX_PARTITIONS-1];
  logic [BCNT_W-1:0]     end_block_next   [0:MAX_PARTITIONS-1];
  logic [15:0]           name_store_next  [0:MAX_PARTITIONS-1];
  logic [2:0]            partition_total_next;
  logic                  mounted_next;
  logic                  names_valid_next;
  out_item_t             res;

  // Load decode
  logic [PACKED_W-1:0]   packed_word;
  logic [START_BITS-1:0] starts [0:MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] live;
  logic [2:0]            n_starts;
  logic [2:0]            load_count;
  logic [2:0]            load_err;
  logic                  load_bad;

  // Selected partition
  logic [START_BITS-1:0] sel_begin;
  logic [BCNT_W-1:0]     sel_end;
  logic [BCNT_W-1:0]     sel_blocks;
  logic                  idx_ok;
  logic                  slot_ok;
  logic [16:0]           byte_end;
  logic [16:0]           bib_end;
  logic [15:0]           blk_sum;

  logic accept;
  logic cfg_write;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid || out_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // Read back registers
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BLOCK_COUNT) begin
      prdata = {{(32-BCNT_W){1'b0}}, block_count};
    end else begin
      prdata = {31'b0, writable};
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BCNT_RESET;
      writable    <= 1'b1;
    end else if (cfg_write) begin
      if (paddr[2] == REG_BLOCK_COUNT) begin
        block_count <= pwdata[BCNT_W-1:0];
      end else begin
        writable <= pwdata[0];
      end
    end
  end

  // Unpack and validate the superblock starts
  always_comb begin
    packed_word = {in_item.packed_high, in_item.packed_low};
    for (int i = 0; i < MAX_PARTITIONS; i++) begin
      starts[i] = packed_word[FLAG_BITS + i*START_BITS +: START_BITS];
    end
    starts[MAX_PARTITIONS] = '0;

    // Entries before the first stop code are live
    n_starts = '0;
    for (int i = 0; i < MAX_PARTITIONS; i++) begin
      live[i] = (starts[i] != START_STOP) && ((i == 0) ? 1'b1 : live[(i > 0) ? i-1 : 0]);
      if (live[i]) begin
        n_starts = 3'(i + 1);
      end
    end

    // Report the first error found
    load_bad = 1'b0;
    load_err = ST_OK;
    if (block_count < BCNT_MIN || block_count > BCNT_MAX) begin
      load_bad = 1'b1;
      load_err = ST_GEOMETRY;
    end else if (in_item.end_marker && n_starts < 3'd2) begin
      load_bad = 1'b1;
      load_err = ST_GEOMETRY;
    end
    for (int i = 0; i < MAX_PARTITIONS; i++) begin
      if (live[i] && !load_bad) begin
        if (starts[i] < MIN_START) begin
          load_bad = 1'b1;
          load_err = ST_GEOMETRY;
        end else if ({1'b0, starts[i]} >= block_count) begin
          load_bad = 1'b1;
          load_err = ST_RANGE;
        end else if (i > 0 && starts[(i > 0) ? i-1 : 0] >= starts[i]) begin
          load_bad = 1'b1;
          load_err = ST_GEOMETRY;
        end
      end
    end

    load_count = in_item.end_marker ? (n_starts - 3'd1) : n_starts;
  end

  // Select the addressed partition
  always_comb begin
    sel_begin = '0;
    sel_end   = '0;
    for (int i = 0; i < MAX_PARTITIONS; i++) begin
      if (in_item.part_index == 3'(i)) begin
        sel_begin = begin_block[i];
        sel_end   = end_block[i];
      end
    end
    sel_blocks = sel_end - {1'b0, sel_begin};
    idx_ok     = in_item.part_index < partition_total;
    slot_ok    = {29'b0, in_item.part_index} < 32'(MAX_PARTITIONS);
    byte_end   = {1'b0, in_item.offset} + {1'b0, in_item.length};
    bib_end    = {9'b0, in_item.byte_in_block} + {1'b0, in_item.length};
    blk_sum    = {4'b0, sel_begin} + in_item.offset;
  end

  // Command logic
  always_comb begin
    res = '0;
    res.status = ST_OK;
    for (int i = 0; i < MAX_PARTITIONS; i++) begin
      begin_block_next[i] = begin_block[i];
      end_block_next[i]   = end_block[i];
      name_store_next[i]  = name_store[i];
    end
    partition_total_next = partition_total;
    mounted_next         = mounted;
    names_valid_next     = names_valid;

    unique case (in_item.cmd)
      CMD_LOAD: begin
        for (int i = 0; i < MAX_PARTITIONS; i++) begin
          name_store_next[i] = '0;
        end
        names_valid_next = 1'b0;
        if (load_bad) begin
          res.status           = load_err;
          mounted_next         = 1'b0;
          partition_total_next = '0;
        end else begin
          for (int i = 0; i < MAX_PARTITIONS; i++) begin
            if (3'(i) < load_count) begin
              begin_block_next[i] = starts[i];
              end_block_next[i]   = (3'(i + 1) < n_starts) ?
                                    {1'b0, starts[i+1]} : block_count;
            end else begin
              begin_block_next[i] = '0;
              end_block_next[i]   = '0;
            end
          end
          mounted_next         = 1'b1;
          partition_total_next = load_count;
        end
      end
      CMD_SET_NAME: begin
        if (!slot_ok) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = 0; i < MAX_PARTITIONS; i++) begin
            if (in_item.part_index == 3'(i)) begin
              name_store_next[i] = in_item.name_tag;
            end
          end
          names_valid_next = 1'b1;
        end
      end
      CMD_FIND: begin
        if (!mounted) begin
          res.status = ST_NOT_READY;
        end else if (names_valid && in_item.name_tag != 16'd0) begin
          // Lowest matching entry wins
          for (int i = MAX_PARTITIONS - 1; i >= 0; i--) begin
            if (3'(i) < partition_total && name_store[i] == in_item.name_tag) begin
              res.found       = 1'b1;
              res.found_index = 3'(i);
            end
          end
        end
      end
      CMD_BYTE, CMD_BLOCK, CMD_IN_BLOCK: begin
        if (!mounted) begin
          res.status = ST_NOT_READY;
        end else if (!idx_ok) begin
          res.status = ST_RANGE;
        end else if (in_item.is_write && !writable) begin
          res.status = ST_READ_ONLY;
        end else if (in_item.cmd == CMD_BYTE) begin
          if (in_item.length != 16'd0) begin
            if (byte_end > {1'b0, sel_blocks[11:0], 4'b0}) begin
              res.status = ST_RANGE;
            end else begin
              res.address      = {sel_begin, 4'b0} + in_item.offset;
              res.issue_access = 1'b1;
            end
          end
        end else if (in_item.cmd == CMD_BLOCK) begin
          if (in_item.offset >= {3'b0, sel_blocks}) begin
            res.status = ST_RANGE;
          end else begin
            res.address      = blk_sum;
            res.issue_access = 1'b1;
          end
        end else begin
          if (in_item.length == 16'd0) begin
            res.status = ST_RANGE;
          end else if (in_item.byte_in_block >= 8'(BLOCK_BYTES) ||
                       bib_end > 17'(BLOCK_BYTES)) begin
            res.status = ST_UNALIGNED;
          end else if (in_item.offset >= {3'b0, sel_blocks}) begin
            res.status = ST_RANGE;
          end else begin
            res.address      = {blk_sum[15-BLOCK_SHIFT:0], 4'b0} +
                               {8'b0, in_item.byte_in_block};
            res.issue_access = 1'b1;
          end
        end
      end
      CMD_SIZE: begin
        if (mounted && idx_ok) begin
          res.size_blocks = sel_blocks;
        end
      end
      default: begin
        res.status = ST_RANGE;
      end
    endcase

    res.part_count = partition_total_next;
  end

  // Commit state on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PARTITIONS; i++) begin
        begin_block[i] <= '0;
        end_block[i]   <= '0;
        name_store[i]  <= '0;
      end
      partition_total <= '0;
      mounted         <= 1'b0;
      names_valid     <= 1'b0;
    end else if (accept) begin
      for (int i = 0; i < MAX_PARTITIONS; i++) begin
        begin_block[i] <= begin_block_next[i];
        end_block[i]   <= end_block_next[i];
        name_store[i]  <= name_store_next[i];
      end
      partition_total <= partition_total_next;
      mounted         <= mounted_next;
      names_valid     <= names_valid_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= res;
    end
  end

endmodule
